// ----- rtl/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// spf_pkg
// shared types and constants of the servo bus packet framer
// ----------------------------------------------------------------------------
package spf_pkg;

    // stream word widths, zero padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int S_TUSER_W = 1;
    localparam int M_TUSER_W = 2;

    // index of a byte inside a command packet (at most nine bytes)
    localparam int IDX_W = 4;

    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] INS_READ   = 8'h02;
    localparam logic [7:0] INS_WRITE  = 8'h03;
    localparam logic [7:0] INS_RESET  = 8'h06;
    localparam logic [7:0] LEN_RESET  = 8'h02;
    localparam logic [7:0] LEN_SHORT  = 8'h04;
    localparam logic [7:0] LEN_WORD   = 8'h05;
    localparam logic [7:0] RD_COUNT_1 = 8'h01;
    localparam logic [7:0] RD_COUNT_2 = 8'h02;

    typedef enum logic [2:0] {
        CMD_WRITE_BYTE = 3'd0,
        CMD_WRITE_WORD = 3'd1,
        CMD_FACTORY    = 3'd2,
        CMD_READ_BYTE  = 3'd3,
        CMD_READ_WORD  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_HDR2   = 3'd1,
        PH_ID     = 3'd2,
        PH_LEN    = 3'd3,
        PH_ERROR  = 3'd4,
        PH_LOW    = 3'd5,
        PH_HIGH   = 3'd6,
        PH_CHKSUM = 3'd7
    } t_rx_phase;

    // one transmit byte of a command packet
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_tx;

    // result of one received byte
    typedef struct packed {
        logic        valid;
        logic        ok;
        logic [7:0]  id;
        logic [7:0]  error;
        logic [15:0] value;
    } t_status;

endpackage

// ----- rtl/servo_bus_packet_framer.sv -----
// a word is taken into the input register, and its results then leave through the output register
// throughput: one packet byte per cycle while the output is free (6, 8 or 9 per command),
//   set by the single byte selector behind the input register
// a received byte gives a single result; an unknown command is dropped on entry
// reset (synchronous, active low) empties both stages and the parser
// ----------------------------------------------------------------------------
// servo_bus_packet_framer
// frames servo bus commands into bytes and parses received status packets
// ----------------------------------------------------------------------------
module servo_bus_packet_framer
    import spf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: servo_id[7:0], command[10:8], reg_addr[18:11],
    //        write_value[34:19], rx_byte[42:35], zero[47:43]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: op[0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    // master side
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: tx_byte[7:0], status_ok[8], status_id[16:9],
    //        status_error[24:17], read_value[40:25], zero[47:41]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // tuser: tx_valid[0], status_valid[1]
    output logic [M_TUSER_W-1:0] m_axis_tuser,
    output logic                 m_axis_tlast
);

    // input stage: the word being worked on and its byte position
    logic             r_in_valid, n_in_valid;
    logic             r_in_op;
    logic [7:0]       r_in_id;
    logic [2:0]       r_in_cmd;
    logic [7:0]       r_in_addr;
    logic [15:0]      r_in_value;
    logic [7:0]       r_in_rx;
    logic [IDX_W-1:0] r_idx, n_idx;

    // output stage
    logic             r_out_valid;
    logic             r_out_tx_valid;
    logic             r_out_last;
    t_status          r_out_status;
    logic [7:0]       r_out_tx_byte;

    t_tx              gen_tx;
    t_status          rx_status;
    logic             out_free;
    logic             adv;
    logic             cur_last;
    logic             s_acc;
    logic             keep;
    logic             width_we;

    spf_cmd_gen u_cmd_gen (
        .i_id    (r_in_id),
        .i_cmd   (r_in_cmd),
        .i_addr  (r_in_addr),
        .i_value (r_in_value),
        .i_idx   (r_idx),
        .o_tx    (gen_tx)
    );

    // read commands set the reply width as their last byte leaves
    assign width_we = adv && !r_in_op && gen_tx.last &&
                      ((r_in_cmd == CMD_READ_BYTE) || (r_in_cmd == CMD_READ_WORD));

    spf_rx_parser u_rx_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (adv && r_in_op),
        .i_byte       (r_in_rx),
        .i_width_we   (width_we),
        .i_width_word (r_in_cmd == CMD_READ_WORD),
        .o_status     (rx_status)
    );

    // handshake: a result moves whenever the output register is free
    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign cur_last      = r_in_op ? 1'b1 : gen_tx.last;
    assign s_axis_tready = !r_in_valid || (adv && cur_last);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    // unknown commands give no bytes, so they never enter the stage
    assign keep          = s_axis_tuser[0] || (s_axis_tdata[10:8] <= CMD_READ_WORD);

    always_comb begin
        n_in_valid = r_in_valid;
        n_idx      = r_idx;
        if (s_acc) begin
            n_in_valid = keep;
            n_idx      = '0;
        end else if (adv) begin
            n_in_valid = !cur_last;
            n_idx      = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_idx      <= n_idx;
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_op    <= s_axis_tuser[0];
            r_in_id    <= s_axis_tdata[7:0];
            r_in_cmd   <= s_axis_tdata[10:8];
            r_in_addr  <= s_axis_tdata[18:11];
            r_in_value <= s_axis_tdata[34:19];
            r_in_rx    <= s_axis_tdata[42:35];
        end
        if (adv) begin
            r_out_tx_valid <= !r_in_op;
            r_out_last     <= cur_last;
            r_out_tx_byte  <= r_in_op ? 8'h00 : gen_tx.tx_byte;
            r_out_status   <= r_in_op ? rx_status : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_status.valid, r_out_tx_valid};
    assign m_axis_tdata  = {7'b0, r_out_status.value, r_out_status.error,
                            r_out_status.id, r_out_status.ok, r_out_tx_byte};

`ifndef ASSERT_OFF
    // an empty input stage always takes a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stage empty but not ready");

    // a command never runs past its checksum byte
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_op) |-> (r_idx <= IDX_W'(8)))
        else $error("command byte index out of range");

    // a received byte gives one final result with no transmit byte
    a_rx_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_op) |=> (m_axis_tvalid && m_axis_tlast && !m_axis_tuser[0]))
        else $error("received byte result malformed");

    // status and transmit bytes are never reported together
    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status.valid) |-> !r_out_tx_valid)
        else $error("status result carries a transmit byte");
`endif

endmodule

// ----- rtl/spf_cmd_gen.sv -----
// ----------------------------------------------------------------------------
// spf_cmd_gen
// picks byte number i_idx of a command packet and flags the last one
// ----------------------------------------------------------------------------
module spf_cmd_gen
    import spf_pkg::*;
(
    input  logic [7:0]       i_id,
    input  logic [2:0]       i_cmd,
    input  logic [7:0]       i_addr,
    input  logic [15:0]      i_value,
    input  logic [IDX_W-1:0] i_idx,
    output t_tx              o_tx
);

    logic [7:0]       len;
    logic [7:0]       instr;
    logic [7:0]       p6;
    logic [7:0]       sum;
    logic [7:0]       chk;
    logic [IDX_W-1:0] last_idx;
    logic             is_reset;
    logic             is_word;

    always_comb begin
        len      = LEN_SHORT;
        instr    = INS_WRITE;
        p6       = i_value[7:0];
        last_idx = IDX_W'(7);
        is_reset = 1'b0;
        is_word  = 1'b0;
        unique case (i_cmd)
            CMD_WRITE_BYTE: begin
            end
            CMD_WRITE_WORD: begin
                len      = LEN_WORD;
                last_idx = IDX_W'(8);
                is_word  = 1'b1;
            end
            CMD_FACTORY: begin
                len      = LEN_RESET;
                instr    = INS_RESET;
                last_idx = IDX_W'(5);
                is_reset = 1'b1;
            end
            CMD_READ_BYTE: begin
                instr = INS_READ;
                p6    = RD_COUNT_1;
            end
            CMD_READ_WORD: begin
                instr = INS_READ;
                p6    = RD_COUNT_2;
            end
            default: begin
                last_idx = '0;
            end
        endcase

        sum = i_id + len + instr;
        if (!is_reset) begin
            sum = sum + i_addr + p6 + (is_word ? i_value[15:8] : 8'h00);
        end
        chk = ~sum;

        o_tx.last = (i_idx == last_idx);
        unique case (i_idx)
            IDX_W'(0), IDX_W'(1): o_tx.tx_byte = HDR_BYTE;
            IDX_W'(2):            o_tx.tx_byte = i_id;
            IDX_W'(3):            o_tx.tx_byte = len;
            IDX_W'(4):            o_tx.tx_byte = instr;
            IDX_W'(5):            o_tx.tx_byte = is_reset ? chk : i_addr;
            IDX_W'(6):            o_tx.tx_byte = p6;
            IDX_W'(7):            o_tx.tx_byte = is_word ? i_value[15:8] : chk;
            IDX_W'(8):            o_tx.tx_byte = chk;
            default:              o_tx.tx_byte = 8'h00;
        endcase
    end

endmodule

// ----- rtl/spf_rx_parser.sv -----
// ----------------------------------------------------------------------------
// spf_rx_parser
// status packet parser, one received byte per step
// ----------------------------------------------------------------------------
module spf_rx_parser
    import spf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_width_we,
    input  logic       i_width_word,
    output t_status    o_status
);

    t_rx_phase  r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_ident, n_ident;
    logic [7:0] r_error, n_error;
    logic [7:0] r_low, n_low;
    logic [7:0] r_high, n_high;
    logic       r_expect_word;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_ident = r_ident;
        n_error = r_error;
        n_low   = r_low;
        n_high  = r_high;
        unique case (r_phase)
            PH_HUNT: n_phase = (i_byte == HDR_BYTE) ? PH_HDR2 : PH_HUNT;
            PH_HDR2: n_phase = (i_byte == HDR_BYTE) ? PH_ID : PH_HUNT;
            PH_ID: begin
                n_ident = i_byte;
                n_sum   = i_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_sum   = r_sum + i_byte;
                n_phase = PH_ERROR;
            end
            PH_ERROR: begin
                n_error = i_byte;
                n_sum   = r_sum + i_byte;
                n_phase = PH_LOW;
            end
            PH_LOW: begin
                n_low   = i_byte;
                n_sum   = r_sum + i_byte;
                n_phase = r_expect_word ? PH_HIGH : PH_CHKSUM;
            end
            PH_HIGH: begin
                n_high  = i_byte;
                n_sum   = r_sum + i_byte;
                n_phase = PH_CHKSUM;
            end
            PH_CHKSUM: n_phase = PH_HUNT;
            default:   n_phase = PH_HUNT;
        endcase
    end

    // outputs, all zero unless the checksum byte is being taken
    always_comb begin
        o_status = '0;
        if (r_phase == PH_CHKSUM) begin
            o_status.valid = 1'b1;
            o_status.ok    = (~r_sum == i_byte);
            o_status.id    = r_ident;
            o_status.error = r_error;
            o_status.value = r_expect_word ? {r_high, r_low} : {8'h00, r_low};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_sum         <= '0;
            r_ident       <= '0;
            r_error       <= '0;
            r_low         <= '0;
            r_high        <= '0;
            r_expect_word <= 1'b0;
        end else begin
            if (i_step) begin
                r_phase <= n_phase;
                r_sum   <= n_sum;
                r_ident <= n_ident;
                r_error <= n_error;
                r_low   <= n_low;
                r_high  <= n_high;
            end
            if (i_width_we) begin
                r_expect_word <= i_width_word;
            end
        end
    end

endmodule
